// ===== rtl/mrrb_pkg.sv =====
// mrrb_pkg: shared types, request and status codes, and controller states
// for the multi-reader ring buffer unit. Used by every other file under rtl.
// No dependencies.
package mrrb_pkg;

  // default configuration
  localparam int DEPTH_DEF   = 64;
  localparam int READERS_DEF = 8;

  // request codes
  localparam logic [2:0] REQ_INSERT   = 3'd0;
  localparam logic [2:0] REQ_ADD      = 3'd1;
  localparam logic [2:0] REQ_DELETE   = 3'd2;
  localparam logic [2:0] REQ_EXIT     = 3'd3;
  localparam logic [2:0] REQ_SEEK     = 3'd4;
  localparam logic [2:0] REQ_GET_NEXT = 3'd5;
  localparam logic [2:0] REQ_RELEASE  = 3'd6;
  // spare code, answered ok with no effect
  localparam logic [2:0] REQ_NOP      = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BLOCKED   = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_STOPPED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // request transaction
  typedef struct packed {
    logic [2:0]        req_type;
    logic [2:0]        rdr_num;
    logic [7:0]        reader_mask;
    logic [63:0]       entry_id;
    logic signed [7:0] cmd_code;
    logic [31:0]       data_handle;
    logic [31:0]       byte_len;
    logic [5:0]        entry_index;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        pending_mask;
    logic [5:0]        slot;
    logic [63:0]       out_id;
    logic signed [7:0] out_cmd;
    logic [31:0]       out_handle;
    logic [31:0]       out_size;
    logic              evicted_valid;
    logic [63:0]       evicted_id;
    logic [31:0]       evicted_handle;
  } rsp_t;

  // stored entry payload
  typedef struct packed {
    logic [63:0] id;
    logic [7:0]  cmd;
    logic [31:0] handle;
    logic [31:0] size;
  } ent_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic capture;
    logic issue;
    logic exec;
    logic scan;
    logic load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic is_scan;
    logic scan_last;
    logic out_free;
  } sts_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_WB
  } state_t;

endpackage

// ===== rtl/mrrb_ctrl.sv =====
// mrrb_ctrl: sequencing state machine of the ring buffer unit.
// Depends on mrrb_pkg; drives commands into mrrb_dp.
module mrrb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mrrb_pkg::sts_t  sts,
  output mrrb_pkg::cmd_t  cmd
);

  mrrb_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrrb_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mrrb_pkg::S_CLEAR: if (sts.clear_last) state_next = mrrb_pkg::S_IDLE;
      mrrb_pkg::S_IDLE:  if (req_valid) state_next = mrrb_pkg::S_READ;
      mrrb_pkg::S_READ: begin
        state_next = sts.is_scan ? mrrb_pkg::S_SCAN : mrrb_pkg::S_EXEC;
      end
      mrrb_pkg::S_EXEC:  state_next = mrrb_pkg::S_WB;
      mrrb_pkg::S_SCAN:  if (sts.scan_last) state_next = mrrb_pkg::S_WB;
      mrrb_pkg::S_WB:    if (sts.out_free) state_next = mrrb_pkg::S_IDLE;
      default:           state_next = mrrb_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      mrrb_pkg::S_CLEAR: cmd.clear = 1'b1;
      mrrb_pkg::S_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      mrrb_pkg::S_READ:  cmd.issue = 1'b1;
      mrrb_pkg::S_EXEC:  cmd.exec = 1'b1;
      mrrb_pkg::S_SCAN:  cmd.scan = 1'b1;
      mrrb_pkg::S_WB:    cmd.load = sts.out_free;
      default:           cmd = '0;
    endcase
  end

endmodule

// ===== rtl/mrrb_dp.sv =====
// mrrb_dp: ring memories, reader state, slot walk and result registers.
// Depends on mrrb_pkg; commanded by mrrb_ctrl.
module mrrb_dp #(
  parameter int DEPTH   = mrrb_pkg::DEPTH_DEF,
  parameter int READERS = mrrb_pkg::READERS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  mrrb_pkg::cmd_t cmd,
  output mrrb_pkg::sts_t sts,
  input  mrrb_pkg::req_t req,
  output mrrb_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;

  typedef struct packed {
    logic               written;
    logic [READERS-1:0] pend;
  } slot_st_t;

  // memories
  mrrb_pkg::ent_t ent_mem [DEPTH];
  slot_st_t       st_mem  [DEPTH];
  mrrb_pkg::ent_t ent_rd;
  slot_st_t       st_rd;

  // registers
  mrrb_pkg::req_t     req_q;
  logic [AW-1:0]      tail;
  logic [READERS-1:0] active;
  logic [AW-1:0]      pos [READERS];
  logic [AW-1:0]      scan_j;
  logic [AW-1:0]      cnt;
  logic               found;
  logic [AW-1:0]      at;
  mrrb_pkg::rsp_t     res;

  // combinational
  logic [READERS-1:0] rbit;
  logic               rid_ok;
  logic [RW-1:0]      rid_idx;
  logic [AW-1:0]      pos_cur;
  logic [AW-1:0]      nx;
  logic [AW-1:0]      rd_addr;
  logic               rel_ok;
  logic               match;
  logic               found_f;
  logic [AW-1:0]      at_f;
  logic               ins_ok;
  logic               ent_we;
  logic               st_we;
  logic [AW-1:0]      st_wa;
  slot_st_t           st_wd;
  mrrb_pkg::rsp_t     exec_res;
  mrrb_pkg::rsp_t     scan_res;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] x);
    inc = (32'(x) == DEPTH - 1) ? '0 : x + AW'(1);
  endfunction

  // reader decode
  always_comb begin
    rid_ok  = 32'(req_q.rdr_num) < READERS;
    rid_idx = RW'(req_q.rdr_num);
    rbit    = rid_ok ? (READERS'(1) << req_q.rdr_num) : '0;
    pos_cur = rid_ok ? pos[rid_idx] : '0;
    nx      = inc(pos_cur);
    rel_ok  = 32'(req_q.entry_index) < DEPTH;
  end

  // read address select
  always_comb begin
    if (cmd.scan) begin
      rd_addr = inc(scan_j);
    end else begin
      case (req_q.req_type)
        mrrb_pkg::REQ_GET_NEXT: rd_addr = nx;
        mrrb_pkg::REQ_RELEASE:  rd_addr = AW'(req_q.entry_index);
        default:                rd_addr = tail;
      endcase
    end
  end

  // memory read ports
  always_ff @(posedge clk) begin
    ent_rd <= ent_mem[rd_addr];
    st_rd  <= st_mem[rd_addr];
  end

  // walk match and insert check
  always_comb begin
    match   = st_rd.written && (ent_rd.id == req_q.entry_id) && rid_ok;
    found_f = found || match;
    at_f    = match ? scan_j : at;
    ins_ok  = (st_rd.pend == '0);
    ent_we  = cmd.exec && (req_q.req_type == mrrb_pkg::REQ_INSERT) && ins_ok;
  end

  // slot status write port
  always_comb begin
    st_we = 1'b0;
    st_wa = scan_j;
    st_wd = st_rd;
    if (cmd.clear) begin
      st_we = 1'b1;
      st_wd = '0;
    end else if (cmd.exec) begin
      case (req_q.req_type)
        mrrb_pkg::REQ_INSERT: begin
          st_we = ins_ok;
          st_wa = tail;
          st_wd = {1'b1, active};
        end
        mrrb_pkg::REQ_RELEASE: begin
          st_we      = rel_ok;
          st_wa      = AW'(req_q.entry_index);
          st_wd.pend = st_rd.pend & ~rbit;
        end
        default: st_we = 1'b0;
      endcase
    end else if (cmd.scan) begin
      if (req_q.req_type == mrrb_pkg::REQ_EXIT) begin
        st_we      = 1'b1;
        st_wd.pend = st_rd.pend & ~rbit;
      end else if (match) begin
        st_we      = 1'b1;
        st_wd.pend = st_rd.pend & ~rbit;
      end else if (found && st_rd.written) begin
        st_we      = 1'b1;
        st_wd.pend = st_rd.pend | rbit;
      end
    end
  end

  // memory write ports
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (ent_we) begin
      ent_mem[tail] <= '{id: req_q.entry_id, cmd: req_q.cmd_code,
                         handle: req_q.data_handle, size: req_q.byte_len};
    end
  end

  // single slot result
  always_comb begin
    exec_res = '0;
    case (req_q.req_type)
      mrrb_pkg::REQ_INSERT: begin
        if (!ins_ok) begin
          exec_res.status       = mrrb_pkg::ST_BLOCKED;
          exec_res.pending_mask = 8'(st_rd.pend);
        end else if (st_rd.written && (ent_rd.handle != '0)) begin
          exec_res.evicted_valid  = 1'b1;
          exec_res.evicted_id     = ent_rd.id;
          exec_res.evicted_handle = ent_rd.handle;
        end
      end
      mrrb_pkg::REQ_GET_NEXT: begin
        if (!rid_ok || !(|(active & rbit))) begin
          exec_res.status = mrrb_pkg::ST_STOPPED;
        end else if (nx == tail) begin
          exec_res.status = mrrb_pkg::ST_EMPTY;
        end else begin
          exec_res.slot       = 6'(nx);
          exec_res.out_id     = ent_rd.id;
          exec_res.out_cmd    = ent_rd.cmd;
          exec_res.out_handle = ent_rd.handle;
          exec_res.out_size   = ent_rd.size;
        end
      end
      default: exec_res = '0;
    endcase
  end

  // walk result
  always_comb begin
    scan_res = '0;
    if (req_q.req_type == mrrb_pkg::REQ_SEEK) begin
      if (found_f) begin
        scan_res.slot = 6'(at_f);
      end else begin
        scan_res.status = mrrb_pkg::ST_NOT_FOUND;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tail      <= '0;
      active    <= '0;
      scan_j    <= '0;
      cnt       <= '0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < READERS; i++) pos[i] <= '0;
    end else begin
      if (cmd.clear) scan_j <= inc(scan_j);
      if (cmd.issue) begin
        scan_j <= tail;
        cnt    <= '0;
        found  <= 1'b0;
        if (req_q.req_type == mrrb_pkg::REQ_EXIT) active <= active & ~rbit;
      end
      if (cmd.exec) begin
        case (req_q.req_type)
          mrrb_pkg::REQ_INSERT: if (ins_ok) tail <= inc(tail);
          mrrb_pkg::REQ_ADD:    active <= active | rbit;
          mrrb_pkg::REQ_DELETE: active <= active & ~READERS'(req_q.reader_mask);
          mrrb_pkg::REQ_GET_NEXT: begin
            if (rid_ok && (|(active & rbit)) && (nx != tail)) pos[rid_idx] <= nx;
          end
          default: ;
        endcase
      end
      if (cmd.scan) begin
        scan_j <= inc(scan_j);
        cnt    <= cnt + AW'(1);
        if (match) found <= 1'b1;
        if (sts.scan_last && (req_q.req_type == mrrb_pkg::REQ_SEEK) && found_f) begin
          pos[rid_idx] <= at_f;
        end
      end
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) req_q <= req;
    if (cmd.scan && match) at <= scan_j;
    if (cmd.exec) res <= exec_res;
    if (cmd.scan && sts.scan_last) res <= scan_res;
    if (cmd.load) rsp <= res;
  end

  // status to controller
  always_comb begin
    sts.clear_last = (32'(scan_j) == DEPTH - 1);
    sts.is_scan    = (req_q.req_type == mrrb_pkg::REQ_SEEK) ||
                     (req_q.req_type == mrrb_pkg::REQ_EXIT);
    sts.scan_last  = (32'(cnt) == DEPTH - 1);
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

  // tail pointer stays inside the ring
  assert property (@(posedge clk) disable iff (rst) 32'(tail) < DEPTH)
    else $error("tail pointer outside ring");

  // a blocked insert never touches the entry store
  assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (req_q.req_type == mrrb_pkg::REQ_INSERT) && (st_rd.pend != '0) |-> !ent_we)
    else $error("blocked insert wrote entry");

  // walk write never collides with the prefetch read
  assert property (@(posedge clk) disable iff (rst) cmd.scan && st_we |-> st_wa != rd_addr)
    else $error("walk write hits prefetch address");

  // a result is loaded only into a free output register
  assert property (@(posedge clk) disable iff (rst) cmd.load |-> !rsp_valid || !rsp_stall)
    else $error("result loaded over pending transaction");

endmodule

// ===== rtl/multi_reader_ring_buffer_unit.sv =====
// multi_reader_ring_buffer_unit: top level of the broadcast ring buffer.
// Depends on mrrb_pkg, mrrb_ctrl and mrrb_dp.
//
// Usage:
//   req channel (req_valid/req_stall/req) takes one request transaction:
//   insert, add reader, delete readers, reader exit, seek, get next, release.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one result
//   transaction per request, in request order.
//   One request is in flight at a time. Insert, add, delete, get next and
//   release pass through the read, execute and write-back states; seek and
//   reader exit walk every ring slot through the status memory in the scan
//   state instead of execute. The next request is accepted the cycle after
//   the result moves into the output register.
//   After reset a clearing pass writes every slot status entry, one per
//   cycle, with req_stall high. When the receiver stalls, the result holds
//   in the output register while one more request may be accepted and
//   processed up to its result stage.
module multi_reader_ring_buffer_unit #(
  parameter int DEPTH   = mrrb_pkg::DEPTH_DEF,
  parameter int READERS = mrrb_pkg::READERS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mrrb_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mrrb_pkg::rsp_t rsp
);

  mrrb_pkg::cmd_t cmd;
  mrrb_pkg::sts_t sts;

  // controller
  mrrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  mrrb_dp #(
    .DEPTH   (DEPTH),
    .READERS (READERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

// ===== bench/multi_reader_ring_buffer_unit_tb.sv =====
// multi_reader_ring_buffer_unit_tb: self-checking bench for the broadcast ring buffer.
// Scoreboard class mirrors ring, reader and pending state; depends on mrrb_pkg and the dut.
// Directed requests first, then bursty random traffic with receiver stalls and a long hold.
module multi_reader_ring_buffer_unit_tb;

  // ring mirror and queue of predicted result transactions
  class ring_scoreboard;
    bit [63:0] ids[64];
    bit [7:0]  cmds[64];
    bit [31:0] handles[64];
    bit [31:0] sizes[64];
    bit        written[64];
    bit [7:0]  pend[64];
    bit [5:0]  tail;
    bit [7:0]  active;
    bit [5:0]  pos[8];
    mrrb_pkg::rsp_t exp_q[$];
    int        errors;

    function new();
      tail = '0;
      active = '0;
      errors = 0;
      foreach (written[i]) begin
        written[i] = 0;
        pend[i] = '0;
      end
      foreach (pos[i]) pos[i] = '0;
    endfunction

    // true when a get next would deliver a slot that holds nothing yet
    function bit reads_unwritten(mrrb_pkg::req_t r);
      bit [5:0] nx;
      nx = pos[r.rdr_num] + 6'd1;
      return r.req_type == mrrb_pkg::REQ_GET_NEXT && active[r.rdr_num] && nx != tail &&
             !written[nx];
    endfunction

    // apply one accepted request to the mirror and queue its result
    function void note_request(mrrb_pkg::req_t r);
      mrrb_pkg::rsp_t o;
      bit [7:0]  b;
      bit [5:0]  j;
      bit [5:0]  at;
      bit [5:0]  nx;
      bit        found;
      o = '0;
      b = 8'd1 << r.rdr_num;
      case (r.req_type)
        mrrb_pkg::REQ_INSERT: begin
          if (pend[tail] != 0) begin
            o.status = mrrb_pkg::ST_BLOCKED;
            o.pending_mask = pend[tail];
          end else begin
            if (written[tail] && handles[tail] != 0) begin
              o.evicted_valid = 1'b1;
              o.evicted_id = ids[tail];
              o.evicted_handle = handles[tail];
            end
            ids[tail] = r.entry_id;
            cmds[tail] = r.cmd_code;
            handles[tail] = r.data_handle;
            sizes[tail] = r.byte_len;
            written[tail] = 1;
            pend[tail] = active;
            tail = tail + 6'd1;
          end
        end
        mrrb_pkg::REQ_ADD: active = active | b;
        mrrb_pkg::REQ_DELETE: active = active & ~r.reader_mask;
        mrrb_pkg::REQ_EXIT: begin
          active = active & ~b;
          foreach (pend[i]) pend[i] = pend[i] & ~b;
        end
        mrrb_pkg::REQ_SEEK: begin
          j = tail;
          found = 0;
          at = '0;
          repeat (64) begin
            if (written[j] && ids[j] == r.entry_id) begin
              pend[j] = pend[j] & ~b;
              found = 1;
              at = j;
            end else if (found && written[j]) begin
              pend[j] = pend[j] | b;
            end
            j = j + 6'd1;
          end
          if (!found) o.status = mrrb_pkg::ST_NOT_FOUND;
          else begin
            pos[r.rdr_num] = at;
            o.slot = at;
          end
        end
        mrrb_pkg::REQ_GET_NEXT: begin
          nx = pos[r.rdr_num] + 6'd1;
          if (!active[r.rdr_num]) o.status = mrrb_pkg::ST_STOPPED;
          else if (nx == tail) o.status = mrrb_pkg::ST_EMPTY;
          else begin
            pos[r.rdr_num] = nx;
            o.slot = nx;
            o.out_id = ids[nx];
            o.out_cmd = cmds[nx];
            o.out_handle = handles[nx];
            o.out_size = sizes[nx];
          end
        end
        mrrb_pkg::REQ_RELEASE: pend[r.entry_index] = pend[r.entry_index] & ~b;
        default: ;
      endcase
      exp_q.push_back(o);
    endfunction

    function void cmp(string name, bit [63:0] e, bit [63:0] a);
      if (e != a) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_result(mrrb_pkg::rsp_t a);
      mrrb_pkg::rsp_t e;
      if (exp_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, a);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      cmp("status", 64'(e.status), 64'(a.status));
      cmp("pending_mask", 64'(e.pending_mask), 64'(a.pending_mask));
      cmp("slot", 64'(e.slot), 64'(a.slot));
      cmp("out_id", e.out_id, a.out_id);
      cmp("out_cmd", 64'(e.out_cmd), 64'(a.out_cmd));
      cmp("out_handle", 64'(e.out_handle), 64'(a.out_handle));
      cmp("out_size", 64'(e.out_size), 64'(a.out_size));
      cmp("evicted_valid", 64'(e.evicted_valid), 64'(a.evicted_valid));
      cmp("evicted_id", e.evicted_id, a.evicted_id);
      cmp("evicted_handle", 64'(e.evicted_handle), 64'(a.evicted_handle));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  mrrb_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  mrrb_pkg::rsp_t rsp;

  ring_scoreboard sb = new();
  int stall_pct = 0;
  bit hold_req = 0;
  int burst_left = 0;

  multi_reader_ring_buffer_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver: check accepted results, stall on a random pattern or a long hold
  always @(posedge clk) begin
    int hold_cnt;
    bit hold_done;
    if (rsp_valid && !rsp_stall) sb.check_result(rsp);
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // offer one request and wait until it is taken
  task automatic send_req(mrrb_pkg::req_t r);
    if (sb.reads_unwritten(r)) r.req_type = mrrb_pkg::REQ_INSERT;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  // sender bursts with random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
    req_valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk);
  endtask

  function automatic mrrb_pkg::req_t mk(logic [2:0] op, logic [2:0] rid, logic [63:0] id);
    mrrb_pkg::req_t r;
    r = '0;
    r.req_type = op;
    r.rdr_num = rid;
    r.entry_id = id;
    r.data_handle = 32'd1;
    return r;
  endfunction

  function automatic mrrb_pkg::req_t rand_req();
    mrrb_pkg::req_t r;
    int sel;
    int k;
    r.req_type = mrrb_pkg::REQ_INSERT;
    r.rdr_num = 3'($urandom_range(0, 7));
    r.reader_mask = 8'd1 << $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) r.reader_mask = 8'($urandom);
    r.entry_id = $urandom_range(0, 1) ? 64'($urandom_range(0, 15)) : {$urandom, $urandom};
    r.cmd_code = 8'($urandom);
    r.data_handle = $urandom_range(0, 4) == 0 ? 32'd0 : $urandom;
    r.byte_len = $urandom;
    r.entry_index = sb.pos[r.rdr_num];
    if ($urandom_range(0, 3) == 0) r.entry_index = 6'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 30) r.req_type = mrrb_pkg::REQ_INSERT;
    else if (sel < 55) r.req_type = mrrb_pkg::REQ_GET_NEXT;
    else if (sel < 77) r.req_type = mrrb_pkg::REQ_RELEASE;
    else if (sel < 86) r.req_type = mrrb_pkg::REQ_ADD;
    else if (sel < 93) begin
      r.req_type = mrrb_pkg::REQ_SEEK;
      k = $urandom_range(0, 63);
      if (sb.written[k] && $urandom_range(0, 3) != 0) r.entry_id = sb.ids[k];
    end
    else if (sel < 96) r.req_type = mrrb_pkg::REQ_EXIT;
    else if (sel < 98) r.req_type = mrrb_pkg::REQ_DELETE;
    else r.req_type = mrrb_pkg::REQ_NOP;
    return r;
  endfunction

  initial begin
    mrrb_pkg::req_t r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every request, blocked insert, stopped, empty, not found
    send_req(mk(mrrb_pkg::REQ_GET_NEXT, 3'd0, 64'd0));
    send_req(mk(mrrb_pkg::REQ_ADD, 3'd0, 64'd0));
    send_req(mk(mrrb_pkg::REQ_ADD, 3'd7, 64'd0));
    r = mk(mrrb_pkg::REQ_INSERT, 3'd0, 64'd0);
    r.cmd_code = -8'sd128;
    r.data_handle = '0;
    send_req(r);
    send_req(mk(mrrb_pkg::REQ_GET_NEXT, 3'd0, 64'd0));
    r = mk(mrrb_pkg::REQ_INSERT, 3'd0, '1);
    r.cmd_code = 8'sd127;
    r.data_handle = '1;
    r.byte_len = '1;
    send_req(r);
    send_req(mk(mrrb_pkg::REQ_GET_NEXT, 3'd7, 64'd0));
    send_req(mk(mrrb_pkg::REQ_SEEK, 3'd0, '1));
    send_req(mk(mrrb_pkg::REQ_SEEK, 3'd3, 64'd5));
    send_req(mk(mrrb_pkg::REQ_SEEK, 3'd7, 64'h1234));
    for (int i = 0; i < 62; i++) send_req(mk(mrrb_pkg::REQ_INSERT, 3'd0, 64'(i + 2)));
    send_req(mk(mrrb_pkg::REQ_INSERT, 3'd0, 64'd99));
    r = mk(mrrb_pkg::REQ_RELEASE, 3'd0, 64'd0);
    r.entry_index = 6'd63;
    send_req(r);
    send_req(mk(mrrb_pkg::REQ_EXIT, 3'd7, 64'd0));
    send_req(mk(mrrb_pkg::REQ_INSERT, 3'd0, 64'd77));
    r = mk(mrrb_pkg::REQ_DELETE, 3'd0, 64'd0);
    r.reader_mask = 8'hFF;
    send_req(r);
    send_req(mk(mrrb_pkg::REQ_GET_NEXT, 3'd0, 64'd0));
    send_req(mk(mrrb_pkg::REQ_NOP, 3'd0, 64'd0));
    drain();

    // random phases with varying receiver pressure
    for (int n = 0; n < 1250; n++) begin
      if (n % 250 == 0) stall_pct = $urandom_range(0, 1) ? 0 : $urandom_range(10, 70);
      if (n == 400) hold_req = 1;
      if (n == 700) drain();
      send_req(rand_req());
      if (n % 300 > 40) pace();
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.exp_q.size() == 0 && sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/mrrb_pkg.sv
rtl/mrrb_ctrl.sv
rtl/mrrb_dp.sv
rtl/multi_reader_ring_buffer_unit.sv
bench/multi_reader_ring_buffer_unit_tb.sv
